// ===== rtl/core/mws_pkg.sv =====
// ----------------------------------------------------------------------------
// mws_pkg
// Shared types and constants for the 3x3 maximum window sum unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mws_pkg;

    localparam int WIN       = 3;
    localparam int NUM_ELEMS = WIN * WIN;
    localparam int IDX_W     = $clog2(NUM_ELEMS);
    localparam int POS_BITS  = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_RESET = 3;
    localparam int MIN_SIZE  = 3;
    localparam int APB_W     = 32;
    localparam int ADDR_W    = 3;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/core/mws_in_if.sv =====
// ----------------------------------------------------------------------------
// mws_in_if
// Pixel item channel: valid/ready handshake with one signed pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mws_in_if #(
    parameter int PIXEL_BITS = 16
);

    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/mws_out_if.sv =====
// ----------------------------------------------------------------------------
// mws_out_if
// Result item channel: one value of the best window plus its summary.
// ----------------------------------------------------------------------------
`default_nettype none

interface mws_out_if #(
    parameter int PIXEL_BITS = 16
);
    import mws_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] element;
    logic [PIXEL_BITS+2:0]        best_sum;
    logic [POS_BITS-1:0]          centre_row;
    logic [POS_BITS-1:0]          centre_col;
    logic                         found;
    logic                         last;

    modport source (output valid, output element, output best_sum, output centre_row,
                    output centre_col, output found, output last, input ready);
    modport sink   (input valid, input element, input best_sum, input centre_row,
                    input centre_col, input found, input last, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/mws_line_store.sv =====
// ----------------------------------------------------------------------------
// mws_line_store
// Single-port-read, single-port-write line memory with registered read data.
// Each entry holds the two buffered rows of one column.
// ----------------------------------------------------------------------------
`default_nettype none

module mws_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/max_window_sum_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// max_window_sum_3x3_unit
// Finds the 3x3 window of largest sum in a raster-order frame and returns
// its nine values, sum and centre after the frame's last pixel.
// ----------------------------------------------------------------------------
// Takes one pixel item per clock. Each pixel reads its column's entry of the
// line store (two buffered rows) at accept and writes it back in the next
// cycle; the window sum is compared against the running best in the cycle
// after that, and the nine result items follow via stage 1, stage 2 and the
// output buffer. The nine results drain from it while the next frame
// streams in; only the last pixel of a frame waits, until the previous
// frame's results are all taken. The line store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module max_window_sum_3x3_unit #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    mws_in_if.sink                            pixels,
    mws_out_if.source                         results,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mws_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mws_pkg::APB_W-1:0]    pwdata,
    output logic [mws_pkg::APB_W-1:0]         prdata,
    output logic                              pready
);
    import mws_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CSUM_W = PIXEL_BITS + 2;
    localparam int WSUM_W = PIXEL_BITS + 4;
    localparam int BEST_W = PIXEL_BITS + 3;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEMS - 1);

    typedef logic signed [PIXEL_BITS-1:0] pix_t;
    typedef logic signed [CSUM_W-1:0]     csum_t;

    // configuration
    logic [CFG_W-1:0] row_count_reg;
    logic [CFG_W-1:0] column_count_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= CFG_W'(CFG_RESET);
            column_count_reg <= CFG_W'(CFG_RESET);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ROW_COUNT: row_count_reg    <= pwdata[CFG_W-1:0];
                REG_COL_COUNT: column_count_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ROW_COUNT: prdata = APB_W'(row_count_reg);
            REG_COL_COUNT: prdata = APB_W'(column_count_reg);
            default:       prdata = '0;
        endcase
    end

    // clamped frame size
    logic [COL_W:0] cols_lim;
    logic [ROW_W:0] rows_lim;

    always_comb
    begin
        if (column_count_reg < CFG_W'(MIN_SIZE))
            cols_lim = (COL_W+1)'(MIN_SIZE);
        else if (int'(column_count_reg) > MAX_COLS)
            cols_lim = (COL_W+1)'(MAX_COLS);
        else
            cols_lim = (COL_W+1)'(column_count_reg);

        if (row_count_reg < CFG_W'(MIN_SIZE))
            rows_lim = (ROW_W+1)'(MIN_SIZE);
        else if (int'(row_count_reg) > MAX_ROWS)
            rows_lim = (ROW_W+1)'(MAX_ROWS);
        else
            rows_lim = (ROW_W+1)'(row_count_reg);
    end

    // raster position
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic             col_wrap;
    logic             in_end;
    logic             in_fire;

    assign col_inc  = {1'b0, col_reg} + (COL_W+1)'(1);
    assign row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign col_wrap = col_inc >= cols_lim;
    assign in_end   = col_wrap && (row_inc >= rows_lim);

    // pipeline and output state
    logic                  s1_valid_reg;
    logic                  s1_end_reg;
    logic                  s1_elig_reg;
    pix_t                  s1_px_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic [POS_BITS-1:0]   s1_crow_reg;
    logic [POS_BITS-1:0]   s1_ccol_reg;

    logic                  s2_end_reg;
    logic                  s2_elig_reg;
    logic [POS_BITS-1:0]   s2_crow_reg;
    logic [POS_BITS-1:0]   s2_ccol_reg;
    pix_t                  win_reg [NUM_ELEMS];
    csum_t                 csum_reg [WIN];

    logic [BEST_W-1:0]     best_reg;
    logic                  found_reg;
    pix_t                  best_win_reg [NUM_ELEMS];
    logic [POS_BITS-1:0]   best_crow_reg;
    logic [POS_BITS-1:0]   best_ccol_reg;

    logic                  out_busy_reg;
    logic [IDX_W-1:0]      out_idx_reg;
    pix_t                  out_win_reg [NUM_ELEMS];
    logic [BEST_W-1:0]     out_sum_reg;
    logic [POS_BITS-1:0]   out_crow_reg;
    logic [POS_BITS-1:0]   out_ccol_reg;
    logic                  out_found_reg;
    logic                  out_fire;

    assign pixels.ready = !in_end || (!out_busy_reg && !s1_end_reg && !s2_end_reg);
    assign in_fire      = pixels.valid && pixels.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= in_end ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_reg <= col_inc[COL_W-1:0];
            end
        end
    end

    // line store: {top, mid} per column
    logic [2*PIXEL_BITS-1:0] rd_data;
    pix_t                    top_px;
    pix_t                    mid_px;
    csum_t                   csum_new;

    mws_line_store #(
        .DEPTH (MAX_COLS),
        .WIDTH (2*PIXEL_BITS)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_px, s1_px_reg})
    );

    assign top_px   = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign mid_px   = rd_data[PIXEL_BITS-1:0];
    assign csum_new = CSUM_W'(top_px) + CSUM_W'(mid_px) + CSUM_W'(s1_px_reg);

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_end_reg   <= 1'b0;
            s1_elig_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            s1_end_reg   <= in_fire && in_end;
            s1_elig_reg  <= in_fire && (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg   <= pixels.pixel;
            s1_col_reg  <= col_reg;
            s1_crow_reg <= POS_BITS'(row_reg - ROW_W'(1));
            s1_ccol_reg <= POS_BITS'(col_reg - COL_W'(1));
        end
    end

    // stage 2: window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_end_reg  <= 1'b0;
            s2_elig_reg <= 1'b0;
        end
        else
        begin
            s2_end_reg  <= s1_end_reg;
            s2_elig_reg <= s1_elig_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            for (int k = 0; k < WIN; k++)
            begin
                win_reg[k*WIN]   <= win_reg[k*WIN+1];
                win_reg[k*WIN+1] <= win_reg[k*WIN+2];
            end
            win_reg[WIN-1]       <= top_px;
            win_reg[2*WIN-1]     <= mid_px;
            win_reg[NUM_ELEMS-1] <= s1_px_reg;
            for (int k = 0; k < WIN-1; k++)
            begin
                csum_reg[k] <= csum_reg[k+1];
            end
            csum_reg[WIN-1] <= csum_new;
            s2_crow_reg     <= s1_crow_reg;
            s2_ccol_reg     <= s1_ccol_reg;
        end
    end

    // best tracking
    logic signed [WSUM_W-1:0] wsum;
    logic                     upd;
    logic [BEST_W-1:0]        cand_sum;
    logic                     cand_found;
    pix_t                     cand_win [NUM_ELEMS];
    logic [POS_BITS-1:0]      cand_crow;
    logic [POS_BITS-1:0]      cand_ccol;

    always_comb
    begin
        wsum = '0;
        for (int k = 0; k < WIN; k++)
        begin
            wsum = wsum + WSUM_W'(csum_reg[k]);
        end
        upd        = s2_elig_reg && (wsum > $signed({1'b0, best_reg}));
        cand_sum   = upd ? BEST_W'(wsum) : best_reg;
        cand_found = upd || found_reg;
        cand_crow  = upd ? s2_crow_reg : best_crow_reg;
        cand_ccol  = upd ? s2_ccol_reg : best_ccol_reg;
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            cand_win[k] = upd ? win_reg[k] : best_win_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg  <= '0;
            found_reg <= 1'b0;
        end
        else if (s2_end_reg)
        begin
            best_reg  <= '0;
            found_reg <= 1'b0;
        end
        else if (upd)
        begin
            best_reg  <= cand_sum;
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            best_win_reg  <= win_reg;
            best_crow_reg <= s2_crow_reg;
            best_ccol_reg <= s2_ccol_reg;
        end
    end

    // output buffer
    assign out_fire = out_busy_reg && results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_busy_reg <= 1'b0;
            out_idx_reg  <= '0;
        end
        else if (s2_end_reg)
        begin
            out_busy_reg <= 1'b1;
            out_idx_reg  <= '0;
        end
        else if (out_fire)
        begin
            out_busy_reg <= (out_idx_reg != LAST_IDX);
            out_idx_reg  <= out_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_end_reg)
        begin
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                out_win_reg[k] <= cand_found ? cand_win[k] : '0;
            end
            out_sum_reg   <= cand_sum;
            out_crow_reg  <= cand_found ? cand_crow : '0;
            out_ccol_reg  <= cand_found ? cand_ccol : '0;
            out_found_reg <= cand_found;
        end
        else if (out_fire)
        begin
            for (int k = 0; k < NUM_ELEMS-1; k++)
            begin
                out_win_reg[k] <= out_win_reg[k+1];
            end
        end
    end

    assign results.valid      = out_busy_reg;
    assign results.element    = out_win_reg[0];
    assign results.best_sum   = out_sum_reg;
    assign results.centre_row = out_crow_reg;
    assign results.centre_col = out_ccol_reg;
    assign results.found      = out_found_reg;
    assign results.last       = (out_idx_reg == LAST_IDX);

endmodule

`default_nettype wire

// ===== rtl/core/mws_checker.sv =====
// ----------------------------------------------------------------------------
// mws_checker
// Port-level assertions for the 3x3 maximum window sum unit, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mws_checker #(
    parameter int PIXEL_BITS = 16
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [PIXEL_BITS-1:0]         element,
    input wire logic [PIXEL_BITS+2:0]         best_sum,
    input wire logic [mws_pkg::POS_BITS-1:0]  centre_row,
    input wire logic [mws_pkg::POS_BITS-1:0]  centre_col,
    input wire logic                          found,
    input wire logic                          last,
    input wire logic                          psel,
    input wire logic                          penable,
    input wire logic                          pwrite,
    input wire logic [mws_pkg::ADDR_W-1:0]    paddr,
    input wire logic [mws_pkg::APB_W-1:0]     pwdata,
    input wire logic [mws_pkg::APB_W-1:0]     prdata
);
    import mws_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEMS - 1);

    logic [IDX_W-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            cnt_reg <= last ? '0 : cnt_reg + IDX_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(element) && $stable(last))
        else $error("result item changed while stalled");

    a_last_ninth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (cnt_reg == LAST_IDX)))
        else $error("last not on the ninth item of a run");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |->
            best_sum == '0 && element == '0 && centre_row == '0 && centre_col == '0)
        else $error("no window found but result not zero");

    a_found_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> best_sum != '0)
        else $error("window found with zero sum");

    a_cfg_rd: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2] == REG_ROW_COUNT |=>
            (!psel || paddr[2] != REG_ROW_COUNT ||
             prdata == APB_W'($past(pwdata[CFG_W-1:0]))))
        else $error("row_count read back differs from write");

endmodule

bind max_window_sum_3x3_unit mws_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_mws_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .element    (results.element),
    .best_sum   (results.best_sum),
    .centre_row (results.centre_row),
    .centre_col (results.centre_col),
    .found      (results.found),
    .last       (results.last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
);

`default_nettype wire
